/* rtl/core/descending_sort_second_max_top_defines.svh */
// Assertion macros for the descending sorter RTL.
// Included by files that carry concurrent assertions; needs no package.
`ifndef DESCENDING_SORT_SECOND_MAX_TOP_DEFINES_SVH
`define DESCENDING_SORT_SECOND_MAX_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define DSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// Check that the consequent holds in the cycle the antecedent holds.
`define DSM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");
`else
`define DSM_ASSERT(lbl, clk, rst_n, prop)
`define DSM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/dsm_pkg.sv */
// Shared constants for the descending sorter.
// No dependencies; used by the channel interfaces and the top level.
package dsm_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

endpackage

/* rtl/core/dsm_item_if.sv */
// Input channel of the sorter: one element per request.
// Depends on dsm_pkg.
interface dsm_item_if;
    import dsm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] item_value;
    logic                     item_last;

    modport source (output valid, output item_value, output item_last, input ready);
    modport sink   (input valid, input item_value, input item_last, output ready);
endinterface

/* rtl/core/dsm_result_if.sv */
// Output channel of the sorter: one sorted element per request.
// Depends on dsm_pkg.
interface dsm_result_if;
    import dsm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     run_last;
    logic signed [DATA_W-1:0] second_value;
    logic                     second_found;
    logic                     overflowed;

    modport source (
        output valid, output sorted_value, output run_last,
        output second_value, output second_found, output overflowed,
        input  ready
    );
    modport sink (
        input  valid, input sorted_value, input run_last,
        input  second_value, input second_found, input overflowed,
        output ready
    );
endinterface

/* rtl/core/descending_sort_second_max_top.sv */
// Descending sorter with second-largest search, top level.
// Depends on dsm_pkg, dsm_item_if, dsm_result_if, dsm_ram and the defines header.
//
// Elements arrive one per request on the item channel and are written to an
// element memory of MAX_ITEMS entries, one per cycle; elements beyond
// capacity are dropped and flagged in the overflowed field of every result of
// that run. The request marked item_last closes the set. The block then runs
// an exchange sort over the memory: for each position i it holds the current
// candidate in a register and streams positions i+1..n-1 through the single
// read port, writing back the smaller value whenever a later entry is larger.
// At the end of each pass position i is final and goes to the output register
// once it is free, so results come out in descending order while sorting continues.
// Each pass reads through the registered memory read port, and a stalled result
// channel holds the run between passes. The final result (run_last) carries the
// largest value strictly below the maximum and second_found; when all values
// are equal second_value is 0 and second_found is 0. The item channel stays
// closed from the last request until the final result is loaded into the
// output register; the next set can load while that result waits.
`include "descending_sort_second_max_top_defines.svh"

module descending_sort_second_max_top (
    input  logic         clk,
    input  logic         rst_n,
    dsm_item_if.sink     item,
    dsm_result_if.source result
);
    import dsm_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // control
    state_t                   state_reg,   state_next;
    logic [CNT_W-1:0]         count_reg,   count_next;
    logic                     ovf_reg,     ovf_next;
    logic [ADDR_W-1:0]        i_reg,       i_next;
    logic [CNT_W-1:0]         rd_idx_reg,  rd_idx_next;
    logic                     rvalid_reg,  rvalid_next;
    logic                     rhead_reg,   rhead_next;
    logic                     rlast_reg,   rlast_next;
    logic [ADDR_W-1:0]        ridx_reg,    ridx_next;
    // sort datapath
    logic signed [DATA_W-1:0] cur_reg,     cur_next;
    logic signed [DATA_W-1:0] max_reg,     max_next;
    logic signed [DATA_W-1:0] sec_reg,     sec_next;
    logic                     found_reg,   found_next;
    // output register
    logic                     res_valid_reg,  res_valid_next;
    logic signed [DATA_W-1:0] res_value_reg,  res_value_next;
    logic                     res_last_reg,   res_last_next;
    logic signed [DATA_W-1:0] res_second_reg, res_second_next;
    logic                     res_found_reg,  res_found_next;
    logic                     res_ovf_reg,    res_ovf_next;

    // memory port signals
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic signed [DATA_W-1:0] rd_value;

    logic item_accept;
    logic has_room;
    logic issue;
    logic swap;
    logic out_free;
    logic last_pos;
    logic eff_found;
    logic signed [DATA_W-1:0] eff_sec;

    assign rd_value    = $signed(ram_rdata);
    assign item.ready  = (state_reg == ST_LOAD);
    assign item_accept = item.valid && item.ready;
    assign has_room    = (count_reg < CNT_W'(MAX_ITEMS));

    // issue one read per cycle while the pass has entries left
    assign issue    = (state_reg == ST_SCAN) && (rd_idx_reg < count_reg);
    // a later entry larger than the held candidate: swap the two
    assign swap     = rvalid_reg && !rhead_reg && (cur_reg < rd_value);
    assign out_free = !res_valid_reg || result.ready;
    assign last_pos = (CNT_W'(i_reg) == (count_reg - CNT_W'(1)));

    // second-largest seen so far, including the value now being emitted
    assign eff_found = (i_reg != '0) && (found_reg || (cur_reg < max_reg));
    assign eff_sec   = found_reg ? sec_reg : cur_reg;

    // load writes and swap write-backs never coincide: they live in different states
    assign ram_we    = (item_accept && has_room) || swap;
    assign ram_waddr = item_accept ? count_reg[ADDR_W-1:0] : ridx_reg;
    assign ram_wdata = item_accept ? item.item_value : cur_reg;
    assign ram_raddr = rd_idx_reg[ADDR_W-1:0];

    dsm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_element_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        rd_idx_next     = rd_idx_reg;
        rvalid_next     = 1'b0;
        rhead_next      = rhead_reg;
        rlast_next      = rlast_reg;
        ridx_next       = ridx_reg;
        cur_next        = cur_reg;
        max_next        = max_reg;
        sec_next        = sec_reg;
        found_next      = found_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_value_next  = res_value_reg;
        res_last_next   = res_last_reg;
        res_second_next = res_second_reg;
        res_found_next  = res_found_reg;
        res_ovf_next    = res_ovf_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (item_accept)
                begin
                    // store the element, or drop it and flag the run
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.item_last)
                    begin
                        state_next  = ST_SCAN;
                        i_next      = '0;
                        rd_idx_next = '0;
                    end
                end
            end

            ST_SCAN:
            begin
                // advance the read stream, tag what comes back next cycle
                rvalid_next = issue;
                rhead_next  = (rd_idx_reg == CNT_W'(i_reg));
                rlast_next  = (rd_idx_reg == (count_reg - CNT_W'(1)));
                ridx_next   = rd_idx_reg[ADDR_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (rvalid_reg)
                begin
                    if (rhead_reg || swap)
                    begin
                        cur_next = rd_value;
                    end
                    if (rlast_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_EMIT:
            begin
                // hold the finished position until the output register frees up
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_value_next  = cur_reg;
                    res_last_next   = last_pos;
                    res_found_next  = last_pos && eff_found;
                    res_second_next = (last_pos && eff_found) ? eff_sec : '0;
                    res_ovf_next    = ovf_reg;

                    if (i_reg == '0)
                    begin
                        max_next   = cur_reg;
                        found_next = 1'b0;
                    end
                    else if (!found_reg && (cur_reg < max_reg))
                    begin
                        sec_next   = cur_reg;
                        found_next = 1'b1;
                    end

                    if (last_pos)
                    begin
                        state_next = ST_LOAD;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        state_next  = ST_SCAN;
                        i_next      = i_reg + ADDR_W'(1);
                        rd_idx_next = CNT_W'(i_reg) + CNT_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            rd_idx_reg     <= '0;
            rvalid_reg     <= 1'b0;
            rhead_reg      <= 1'b0;
            rlast_reg      <= 1'b0;
            ridx_reg       <= '0;
            cur_reg        <= '0;
            max_reg        <= '0;
            sec_reg        <= '0;
            found_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_value_reg  <= '0;
            res_last_reg   <= 1'b0;
            res_second_reg <= '0;
            res_found_reg  <= 1'b0;
            res_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            i_reg          <= i_next;
            rd_idx_reg     <= rd_idx_next;
            rvalid_reg     <= rvalid_next;
            rhead_reg      <= rhead_next;
            rlast_reg      <= rlast_next;
            ridx_reg       <= ridx_next;
            cur_reg        <= cur_next;
            max_reg        <= max_next;
            sec_reg        <= sec_next;
            found_reg      <= found_next;
            res_valid_reg  <= res_valid_next;
            res_value_reg  <= res_value_next;
            res_last_reg   <= res_last_next;
            res_second_reg <= res_second_next;
            res_found_reg  <= res_found_next;
            res_ovf_reg    <= res_ovf_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.sorted_value = res_value_reg;
    assign result.run_last     = res_last_reg;
    assign result.second_value = res_second_reg;
    assign result.second_found = res_found_reg;
    assign result.overflowed   = res_ovf_reg;

    // the element count never exceeds the memory depth
    `DSM_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_ITEMS))
    // a swap write-back never lands on the entry being read in the same cycle
    `DSM_ASSERT_IMPLY(a_no_rw_clash, clk, rst_n, swap && issue, ram_waddr != ram_raddr)
    // only the final result of a run carries a second value
    `DSM_ASSERT_IMPLY(a_second_final, clk, rst_n, result.valid && !result.run_last, !result.second_found && (result.second_value == '0))
    // memory writes during sorting come only from swaps of non-head entries
    `DSM_ASSERT_IMPLY(a_swap_only, clk, rst_n, ram_we && (state_reg == ST_SCAN), rvalid_reg && !rhead_reg)

endmodule

/* rtl/core/dsm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* test/tb_descending_sort_second_max_top.sv */
// Self-checking testbench for descending_sort_second_max_top.
// Depends on dsm_pkg, dsm_item_if, dsm_result_if and the sorter RTL.
// Drives sets of signed elements with random gaps and stalls; checks each sorted result in order.
`timescale 1ns / 1ps

module tb_descending_sort_second_max_top;
    import dsm_pkg::*;

    // One expected sorted result, field for field as the result channel carries it.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        bit                       fin;
        logic signed [DATA_W-1:0] second;
        bit                       found;
        bit                       dropped;
    } sorted_entry_t;

    // A row of the directed stimulus. Rows marked typed carry their own
    // expected result. Only single-element sets are typed, so the sorted value
    // is the element itself, nothing is below the maximum and nothing is dropped.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        bit                       last;
        bit                       typed;
        logic signed [DATA_W-1:0] exp_value;
    } directed_row_t;

    localparam int NUM_DIRECTED = 20;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // Single elements at the extremes and around zero.
        '{32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff},
        '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000},
        '{32'sh00000000, 1'b1, 1'b1, 32'sh00000000},
        '{-32'sd1,       1'b1, 1'b1, -32'sd1},
        // Mixed set with both extremes and a repeated value.
        '{32'sd5,        1'b0, 1'b0, 32'sd0},
        '{-32'sd1,       1'b0, 1'b0, 32'sd0},
        '{32'sh7fffffff, 1'b0, 1'b0, 32'sd0},
        '{32'sh80000000, 1'b0, 1'b0, 32'sd0},
        '{32'sd5,        1'b0, 1'b0, 32'sd0},
        '{32'sd0,        1'b1, 1'b0, 32'sd0},
        // All equal: no value below the maximum.
        '{32'sd7,        1'b0, 1'b0, 32'sd0},
        '{32'sd7,        1'b0, 1'b0, 32'sd0},
        '{32'sd7,        1'b1, 1'b0, 32'sd0},
        // Two copies of the most negative value.
        '{32'sh80000000, 1'b0, 1'b0, 32'sd0},
        '{32'sh80000000, 1'b1, 1'b0, 32'sd0},
        // Repeated maximum with the next value just below it.
        '{32'sh7fffffff, 1'b0, 1'b0, 32'sd0},
        '{32'sh7fffffff, 1'b0, 1'b0, 32'sd0},
        '{32'sh7ffffffe, 1'b1, 1'b0, 32'sd0},
        // Ascending pair that has to be swapped.
        '{32'sd1,        1'b0, 1'b0, 32'sd0},
        '{32'sd2,        1'b1, 1'b0, 32'sd0}
    };

    logic clk;
    logic rst_n;

    dsm_item_if   item ();
    dsm_result_if result ();

    descending_sort_second_max_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    // Predictor state: the elements collected so far for the current set.
    logic signed [DATA_W-1:0] held_elements [MAX_ITEMS];
    int                       held_count;
    bit                       dropped_any;

    sorted_entry_t expected_sorted [$];

    int mismatches;
    int results_seen;
    int elements_sent;
    int sets_sent;
    int overflow_sets;

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Collect one accepted element; on the last one of a set, sort descending
    // by exchange, find the largest value below the maximum, and queue one
    // expected result per held element.
    task automatic absorb_element(input logic signed [DATA_W-1:0] v, input bit last);
        int                       i;
        int                       j;
        logic signed [DATA_W-1:0] swap;
        logic signed [DATA_W-1:0] second;
        bit                       found;
        sorted_entry_t            e;
        if (held_count < MAX_ITEMS)
        begin
            held_elements[held_count] = v;
            held_count++;
        end
        else
            dropped_any = 1'b1;
        if (!last)
            return;
        for (i = 0; i + 1 < held_count; i++)
            for (j = i + 1; j < held_count; j++)
                if (held_elements[i] < held_elements[j])
                begin
                    swap             = held_elements[i];
                    held_elements[i] = held_elements[j];
                    held_elements[j] = swap;
                end
        second = '0;
        found  = 1'b0;
        for (i = 1; i < held_count && !found; i++)
            if (held_elements[i] < held_elements[0])
            begin
                second = held_elements[i];
                found  = 1'b1;
            end
        for (i = 0; i < held_count; i++)
        begin
            e.value   = held_elements[i];
            e.fin     = (i + 1 == held_count);
            e.second  = e.fin ? second : '0;
            e.found   = e.fin ? found : 1'b0;
            e.dropped = dropped_any;
            expected_sorted.push_back(e);
        end
        if (dropped_any)
            overflow_sets++;
        sets_sent++;
        held_count  = 0;
        dropped_any = 1'b0;
    endtask

    // Present one request at the falling edge and hold it until it is taken.
    // valid is left high; the caller drops it only when a gap follows.
    task automatic send_element(input logic signed [DATA_W-1:0] v, input bit last);
        @(negedge clk);
        item.valid      <= 1'b1;
        item.item_value <= v;
        item.item_last  <= last;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        elements_sent++;
    endtask

    // Idle the sender for a random time: mostly short, now and then long.
    task automatic sender_gap(input bit quiet);
        int len;
        if (quiet)
            return;
        if ($urandom_range(0, 15) == 0)
            len = $urandom_range(20, 60);
        else
            len = $urandom_range(0, 3);
        if (len == 0)
            return;
        @(negedge clk);
        item.valid <= 1'b0;
        repeat (len - 1) @(negedge clk);
    endtask

    // Pick an element: narrow sets hit many duplicates, wide sets cover every bit.
    function automatic logic signed [DATA_W-1:0] pick_element(input bit narrow);
        if (narrow)
            return $signed($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return $signed($urandom_range(0, 4)) - 2;
            default: return $signed($urandom);
        endcase
    endfunction

    // Stall the result channel: short stalls, a few long ones, and long
    // stretches with ready held high.
    initial
    begin : result_pacing
        int hold;
        hold         = 0;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if ($urandom_range(0, 9) < 7)
            begin
                result.ready <= 1'b1;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 6);
            end
            else
            begin
                result.ready <= 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
                                                   : $urandom_range(0, 3);
            end
        end
    end

    // Compare every taken result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        sorted_entry_t want;
        if (rst_n && result.valid && result.ready)
        begin
            results_seen++;
            if (expected_sorted.size() == 0)
            begin
                $display("%0t: unexpected result sorted_value=%0d run_last=%0b",
                         $time, result.sorted_value, result.run_last);
                mismatches++;
            end
            else
            begin
                want = expected_sorted.pop_front();
                if (result.sorted_value !== want.value)
                begin
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, want.value, result.sorted_value);
                    mismatches++;
                end
                if (result.run_last !== want.fin)
                begin
                    $display("%0t: run_last expected %0b actual %0b",
                             $time, want.fin, result.run_last);
                    mismatches++;
                end
                if (result.second_value !== want.second)
                begin
                    $display("%0t: second_value expected %0d actual %0d",
                             $time, want.second, result.second_value);
                    mismatches++;
                end
                if (result.second_found !== want.found)
                begin
                    $display("%0t: second_found expected %0b actual %0b",
                             $time, want.found, result.second_found);
                    mismatches++;
                end
                if (result.overflowed !== want.dropped)
                begin
                    $display("%0t: overflowed expected %0b actual %0b",
                             $time, want.dropped, result.overflowed);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("tb_descending_sort_second_max_top failed");
        $finish;
    end

    initial
    begin : stimulus
        sorted_entry_t e;
        int            set_idx;
        int            set_size;
        int            k;
        bit            narrow;
        bit            quiet;

        rst_n           = 1'b0;
        item.valid      = 1'b0;
        item.item_value = '0;
        item.item_last  = 1'b0;
        held_count      = 0;
        dropped_any     = 1'b0;
        mismatches      = 0;
        results_seen    = 0;
        elements_sent   = 0;
        sets_sent       = 0;
        overflow_sets   = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: walk the table. Typed rows are single-element sets,
        // so the predictor state is empty before and after them and their
        // expectation is queued straight from the table.
        for (k = 0; k < NUM_DIRECTED; k++)
        begin
            send_element(directed_rows[k].value, directed_rows[k].last);
            if (directed_rows[k].typed)
            begin
                e.value   = directed_rows[k].exp_value;
                e.fin     = 1'b1;
                e.second  = '0;
                e.found   = 1'b0;
                e.dropped = 1'b0;
                expected_sorted.push_back(e);
                sets_sent++;
            end
            else
                absorb_element(directed_rows[k].value, directed_rows[k].last);
            sender_gap(1'b0);
        end

        // Random part: mostly small sets, plus one set that overruns the
        // store, dropping several elements and its last request, and one
        // that fills the store exactly.
        set_idx = 0;
        while (elements_sent < 200)
        begin
            case (set_idx)
                2:       set_size = MAX_ITEMS + 6;
                5:       set_size = MAX_ITEMS;
                default: set_size = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                                : $urandom_range(1, 8);
            endcase
            narrow = ($urandom_range(0, 2) == 0);
            quiet  = ($urandom_range(0, 3) == 0);

            // Hold the next set back until the previous runs have drained;
            // drop valid first so the last request is not offered again.
            if (set_idx == 5 || $urandom_range(0, 7) == 0)
            begin
                @(negedge clk);
                item.valid <= 1'b0;
                while (expected_sorted.size() != 0)
                    @(posedge clk);
            end

            for (k = 0; k < set_size; k++)
            begin
                e.value = pick_element(narrow);
                send_element(e.value, k == set_size - 1);
                absorb_element(e.value, k == set_size - 1);
                sender_gap(quiet);
            end
            set_idx++;
        end

        @(negedge clk);
        item.valid <= 1'b0;

        while (expected_sorted.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d elements in %0d sets (%0d with dropped elements).",
                 elements_sent, sets_sent, overflow_sets);
        $display("Checked %0d sorted results; %0d field mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0)
            $display("tb_descending_sort_second_max_top passed");
        else
            $display("tb_descending_sort_second_max_top failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/dsm_pkg.sv
rtl/core/dsm_item_if.sv
rtl/core/dsm_result_if.sv
rtl/core/dsm_ram.sv
rtl/core/descending_sort_second_max_top.sv
test/tb_descending_sort_second_max_top.sv
